// ----- src/multi_algorithm_sorter_assert.svh -----
// ----------------------------------------------------------------------------
// multi_algorithm_sorter_assert
// assertion helpers shared by the sorter rtl
// ----------------------------------------------------------------------------
`ifndef MULTI_ALGORITHM_SORTER_ASSERT_SVH
`define MULTI_ALGORITHM_SORTER_ASSERT_SVH

// same-cycle implication
`define MAS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorter assertion failed");

// next-cycle implication
`define MAS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorter assertion failed");

`endif

// ----- src/mas_pkg.sv -----
// ----------------------------------------------------------------------------
// mas_pkg
// types, constants and helpers shared by the sorter modules
// ----------------------------------------------------------------------------
package mas_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int VALUE_WIDTH  = 32;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int TOTAL_W      = 12;
   localparam int DEPTH_W      = 7;
   localparam int ALG_W        = 3;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   localparam logic [ALG_W-1:0] ALG_BUBBLE    = 3'd0;
   localparam logic [ALG_W-1:0] ALG_SELECTION = 3'd1;
   localparam logic [ALG_W-1:0] ALG_INSERTION = 3'd2;
   localparam logic [ALG_W-1:0] ALG_MERGE     = 3'd3;
   localparam logic [ALG_W-1:0] ALG_QUICK     = 3'd4;
   localparam logic [ALG_W-1:0] ALG_HEAP      = 3'd5;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [IDX_W-1:0]              addr_type;
   typedef logic [CNT_W-1:0]              cnt_type;
   typedef logic [TOTAL_W-1:0]            total_type;
   typedef logic [DEPTH_W-1:0]            depth_type;

   typedef struct packed {
      value_type element_value;
      logic      last_element;
   } req_payload_type;

   typedef struct packed {
      value_type sorted_value;
      addr_type  position;
      total_type comparison_count;
      total_type swap_count;
      depth_type max_depth;
      logic      overflowed;
      logic      last_result;
   } rsp_payload_type;

   typedef struct packed {
      addr_type  lo;
      addr_type  hi;
      depth_type lvl;
      logic      open;
   } frame_type;

   typedef struct packed {
      addr_type  rd_addr_a;
      addr_type  rd_addr_b;
      logic      we;
      addr_type  wr_addr;
      value_type wr_data;
   } vs_req_type;

   typedef struct packed {
      logic             start;
      cnt_type          n;
      logic [ALG_W-1:0] alg;
   } eng_cmd_type;

   typedef struct packed {
      logic      done;
      total_type cmp;
      total_type swp;
      depth_type dep;
   } eng_res_type;

   function automatic total_type sat_inc(input total_type c);
      sat_inc = (c == TOTAL_MAX) ? c : c + total_type'(1);
   endfunction

endpackage

// ----- src/mas_ram.sv -----
// ----------------------------------------------------------------------------
// mas_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module mas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wa,
   input  logic [WIDTH-1:0]         wd,
   input  logic [$clog2(DEPTH)-1:0] ra_a,
   input  logic [$clog2(DEPTH)-1:0] ra_b,
   output logic [WIDTH-1:0]         rd_a,
   output logic [WIDTH-1:0]         rd_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      rd_a <= mem_ff[ra_a];
      rd_b <= mem_ff[ra_b];
   end

endmodule

// ----- src/mas_engine.sv -----
// ----------------------------------------------------------------------------
// mas_engine
// sort sequencer: runs the chosen algorithm on the value store through
// its memory port, owns the merge scratch and range stack memories
// ----------------------------------------------------------------------------
module mas_engine import mas_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  eng_cmd_type cmd,
   output eng_res_type res,
   output vs_req_type  vs_req,
   input  value_type   vs_rd_a,
   input  value_type   vs_rd_b
);

   typedef enum logic [5:0] {
      E_IDLE, E_DONE, E_SW1, E_SW2,
      B_TEST, B_CMP,
      S_I, S_LD, S_J, S_CMP,
      N_I, N_J, N_CMP,
      H_B, H_TOP, H_C1, H_C2, H_DEC, H_E, H_ESW, H_ES,
      Q_INIT, Q_POP, Q_FR, Q_PV, Q_J, Q_CMP, Q_LAST, Q_P1, Q_P2,
      M_INIT, M_TOP, M_FR, M_P1, M_P2,
      R_L, R_C, R_T, R_TW, R_CP, R_CW
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   cnt_type n_ff, n_in, i_ff, i_in, j_ff, j_in, k_ff, k_in, t_ff, t_in;
   cnt_type m_ff, m_in, root_ff, root_in, big_ff, big_in, size_ff, size_in;
   cnt_type lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, sp_ff, sp_in;
   depth_type lvl_ff, lvl_in, dep_ff, dep_in;
   value_type vm_ff, vm_in, vi_ff, vi_in, va_ff, va_in, vb_ff, vb_in;
   addr_type sa_ff, sa_in, sb_ff, sb_in;
   logic tail_a_ff, tail_a_in, hext_ff, hext_in;
   total_type cmp_ff, cmp_in, swp_ff, swp_in;

   logic      scr_we, stk_we;
   addr_type  scr_wa, scr_ra, stk_wa, stk_ra;
   value_type scr_wd, scr_rd;
   frame_type stk_wd, stk_rd, fr;
   logic [CNT_W:0] heap_l, heap_r;
   addr_type  fr_mid;
   cnt_type   sp_m1;

   assign heap_l = {root_ff, 1'b1};
   assign heap_r = heap_l + (CNT_W+1)'(1);
   assign fr     = stk_rd;
   assign fr_mid = fr.lo + ((fr.hi - fr.lo) >> 1);
   assign sp_m1  = sp_ff - cnt_type'(1);

   always_comb begin
      state_in = state_ff;  ret_in  = ret_ff;   n_in    = n_ff;
      i_in     = i_ff;      j_in    = j_ff;     k_in    = k_ff;    t_in   = t_ff;
      m_in     = m_ff;      root_in = root_ff;  big_in  = big_ff;  size_in = size_ff;
      lo_in    = lo_ff;     hi_in   = hi_ff;    mid_in  = mid_ff;  sp_in  = sp_ff;
      lvl_in   = lvl_ff;    dep_in  = dep_ff;   vm_in   = vm_ff;   vi_in  = vi_ff;
      va_in    = va_ff;     vb_in   = vb_ff;    sa_in   = sa_ff;   sb_in  = sb_ff;
      tail_a_in = tail_a_ff; hext_in = hext_ff;
      cmp_in   = cmp_ff;    swp_in  = swp_ff;

      vs_req.rd_addr_a = i_ff[IDX_W-1:0];
      vs_req.rd_addr_b = j_ff[IDX_W-1:0];
      vs_req.we        = 1'b0;
      vs_req.wr_addr   = sa_ff;
      vs_req.wr_data   = vb_ff;
      scr_we = 1'b0;
      scr_wa = k_ff[IDX_W-1:0];
      scr_wd = vs_rd_a;
      scr_ra = t_ff[IDX_W-1:0];
      stk_we = 1'b0;
      stk_wa = sp_ff[IDX_W-1:0];
      stk_wd = '0;
      stk_ra = sp_m1[IDX_W-1:0];
      res.done = 1'b0;
      res.cmp  = cmp_ff;
      res.swp  = swp_ff;
      res.dep  = dep_ff;

      unique case (state_ff)
         E_IDLE: begin
            if (cmd.start) begin
               n_in   = cmd.n;
               cmp_in = '0;
               swp_in = '0;
               dep_in = '0;
               i_in   = '0;
               j_in   = '0;
               case (cmd.alg)
                  ALG_SELECTION: state_in = S_I;
                  ALG_INSERTION: begin
                     i_in     = cnt_type'(1);
                     state_in = N_I;
                  end
                  ALG_MERGE: state_in = M_INIT;
                  ALG_QUICK: begin
                     dep_in   = depth_type'(1);
                     state_in = Q_INIT;
                  end
                  ALG_HEAP: begin
                     i_in     = cmd.n >> 1;
                     hext_in  = 1'b0;
                     state_in = H_B;
                  end
                  default: state_in = B_TEST;
               endcase
            end
         end
         E_DONE: begin
            res.done = 1'b1;
            state_in = E_IDLE;
         end
         // swap writes its two values in turn on the single write port
         E_SW1: begin
            vs_req.we      = 1'b1;
            vs_req.wr_addr = sa_ff;
            vs_req.wr_data = vb_ff;
            swp_in         = sat_inc(swp_ff);
            state_in       = E_SW2;
         end
         E_SW2: begin
            vs_req.we      = 1'b1;
            vs_req.wr_addr = sb_ff;
            vs_req.wr_data = va_ff;
            state_in       = ret_ff;
         end

         B_TEST: begin
            vs_req.rd_addr_a = j_ff[IDX_W-1:0];
            vs_req.rd_addr_b = addr_type'(j_ff + cnt_type'(1));
            if (i_ff == n_ff) begin
               state_in = E_DONE;
            end else if ({1'b0, j_ff} + (CNT_W+1)'(1) < {1'b0, n_ff - i_ff}) begin
               state_in = B_CMP;
            end else begin
               i_in = i_ff + cnt_type'(1);
               j_in = '0;
            end
         end
         B_CMP: begin
            cmp_in = sat_inc(cmp_ff);
            j_in   = j_ff + cnt_type'(1);
            if (vs_rd_a > vs_rd_b) begin
               sa_in    = j_ff[IDX_W-1:0];
               sb_in    = addr_type'(j_ff + cnt_type'(1));
               va_in    = vs_rd_a;
               vb_in    = vs_rd_b;
               ret_in   = B_TEST;
               state_in = E_SW1;
            end else begin
               state_in = B_TEST;
            end
         end

         S_I: begin
            vs_req.rd_addr_a = i_ff[IDX_W-1:0];
            state_in = (i_ff == n_ff) ? E_DONE : S_LD;
         end
         S_LD: begin
            vm_in    = vs_rd_a;
            vi_in    = vs_rd_a;
            m_in     = i_ff;
            j_in     = i_ff + cnt_type'(1);
            state_in = S_J;
         end
         S_J: begin
            vs_req.rd_addr_a = j_ff[IDX_W-1:0];
            if (j_ff < n_ff) begin
               state_in = S_CMP;
            end else begin
               i_in = i_ff + cnt_type'(1);
               if (m_ff != i_ff) begin
                  sa_in    = i_ff[IDX_W-1:0];
                  vb_in    = vm_ff;
                  sb_in    = m_ff[IDX_W-1:0];
                  va_in    = vi_ff;
                  ret_in   = S_I;
                  state_in = E_SW1;
               end else begin
                  state_in = S_I;
               end
            end
         end
         S_CMP: begin
            cmp_in = sat_inc(cmp_ff);
            if (vs_rd_a < vm_ff) begin
               vm_in = vs_rd_a;
               m_in  = j_ff;
            end
            j_in     = j_ff + cnt_type'(1);
            state_in = S_J;
         end

         N_I: begin
            j_in     = i_ff;
            state_in = (i_ff >= n_ff) ? E_DONE : N_J;
         end
         N_J: begin
            vs_req.rd_addr_a = addr_type'(j_ff - cnt_type'(1));
            vs_req.rd_addr_b = j_ff[IDX_W-1:0];
            if (j_ff == '0) begin
               i_in     = i_ff + cnt_type'(1);
               state_in = N_I;
            end else begin
               state_in = N_CMP;
            end
         end
         N_CMP: begin
            cmp_in = sat_inc(cmp_ff);
            if (vs_rd_a <= vs_rd_b) begin
               i_in     = i_ff + cnt_type'(1);
               state_in = N_I;
            end else begin
               sa_in    = addr_type'(j_ff - cnt_type'(1));
               sb_in    = j_ff[IDX_W-1:0];
               va_in    = vs_rd_a;
               vb_in    = vs_rd_b;
               j_in     = j_ff - cnt_type'(1);
               ret_in   = N_J;
               state_in = E_SW1;
            end
         end

         // heap build: i counts the roots still to sift
         H_B: begin
            if (i_ff == '0) begin
               j_in     = n_ff - cnt_type'(1);
               hext_in  = 1'b1;
               state_in = H_E;
            end else begin
               root_in  = i_ff - cnt_type'(1);
               size_in  = n_ff;
               i_in     = i_ff - cnt_type'(1);
               state_in = H_TOP;
            end
         end
         H_TOP: begin
            vs_req.rd_addr_a = root_ff[IDX_W-1:0];
            vs_req.rd_addr_b = heap_l[IDX_W-1:0];
            if (heap_l < {1'b0, size_ff}) begin
               state_in = H_C1;
            end else begin
               state_in = hext_ff ? H_E : H_B;
            end
         end
         H_C1: begin
            cmp_in = sat_inc(cmp_ff);
            vi_in  = vs_rd_a;
            if (vs_rd_b > vs_rd_a) begin
               big_in = heap_l[CNT_W-1:0];
               vm_in  = vs_rd_b;
            end else begin
               big_in = root_ff;
               vm_in  = vs_rd_a;
            end
            vs_req.rd_addr_a = heap_r[IDX_W-1:0];
            state_in = (heap_r < {1'b0, size_ff}) ? H_C2 : H_DEC;
         end
         H_C2: begin
            cmp_in = sat_inc(cmp_ff);
            if (vs_rd_a > vm_ff) begin
               big_in = heap_r[CNT_W-1:0];
               vm_in  = vs_rd_a;
            end
            state_in = H_DEC;
         end
         H_DEC: begin
            if (big_ff == root_ff) begin
               state_in = hext_ff ? H_E : H_B;
            end else begin
               sa_in    = root_ff[IDX_W-1:0];
               vb_in    = vm_ff;
               sb_in    = big_ff[IDX_W-1:0];
               va_in    = vi_ff;
               root_in  = big_ff;
               ret_in   = H_TOP;
               state_in = E_SW1;
            end
         end
         H_E: begin
            vs_req.rd_addr_a = '0;
            vs_req.rd_addr_b = j_ff[IDX_W-1:0];
            state_in = (j_ff == '0) ? E_DONE : H_ESW;
         end
         H_ESW: begin
            sa_in    = '0;
            sb_in    = j_ff[IDX_W-1:0];
            va_in    = vs_rd_a;
            vb_in    = vs_rd_b;
            ret_in   = H_ES;
            state_in = E_SW1;
         end
         H_ES: begin
            root_in  = '0;
            size_in  = j_ff;
            j_in     = j_ff - cnt_type'(1);
            state_in = H_TOP;
         end

         Q_INIT: begin
            stk_wa = '0;
            stk_wd = '{lo: '0, hi: addr_type'(n_ff - cnt_type'(1)),
                       lvl: depth_type'(1), open: 1'b0};
            if (n_ff >= cnt_type'(2)) begin
               stk_we   = 1'b1;
               sp_in    = cnt_type'(1);
               state_in = Q_POP;
            end else begin
               state_in = E_DONE;
            end
         end
         Q_POP: begin
            if (sp_ff == '0) begin
               state_in = E_DONE;
            end else begin
               sp_in    = sp_m1;
               state_in = Q_FR;
            end
         end
         Q_FR: begin
            lo_in  = {1'b0, fr.lo};
            hi_in  = {1'b0, fr.hi};
            lvl_in = fr.lvl;
            i_in   = {1'b0, fr.lo};
            j_in   = {1'b0, fr.lo};
            vs_req.rd_addr_a = fr.hi;
            state_in = Q_PV;
         end
         Q_PV: begin
            vm_in    = vs_rd_a;
            state_in = Q_J;
         end
         Q_J: begin
            if (j_ff < hi_ff) begin
               vs_req.rd_addr_a = j_ff[IDX_W-1:0];
               vs_req.rd_addr_b = i_ff[IDX_W-1:0];
               state_in = Q_CMP;
            end else begin
               vs_req.rd_addr_a = i_ff[IDX_W-1:0];
               state_in = Q_LAST;
            end
         end
         Q_CMP: begin
            cmp_in = sat_inc(cmp_ff);
            j_in   = j_ff + cnt_type'(1);
            if (vs_rd_a < vm_ff) begin
               sa_in    = i_ff[IDX_W-1:0];
               vb_in    = vs_rd_a;
               sb_in    = j_ff[IDX_W-1:0];
               va_in    = vs_rd_b;
               i_in     = i_ff + cnt_type'(1);
               ret_in   = Q_J;
               state_in = E_SW1;
            end else begin
               state_in = Q_J;
            end
         end
         Q_LAST: begin
            sa_in = i_ff[IDX_W-1:0];
            vb_in = vm_ff;
            sb_in = hi_ff[IDX_W-1:0];
            va_in = vs_rd_a;
            if (lvl_ff + depth_type'(1) > dep_ff) begin
               dep_in = lvl_ff + depth_type'(1);
            end
            ret_in   = Q_P1;
            state_in = E_SW1;
         end
         // right part pushed first so the left part pops first
         Q_P1: begin
            stk_wd = '{lo: addr_type'(i_ff + cnt_type'(1)), hi: hi_ff[IDX_W-1:0],
                       lvl: lvl_ff + depth_type'(1), open: 1'b0};
            if ({1'b0, hi_ff} > {1'b0, i_ff} + (CNT_W+1)'(1)) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + cnt_type'(1);
            end
            state_in = Q_P2;
         end
         Q_P2: begin
            stk_wd = '{lo: lo_ff[IDX_W-1:0], hi: addr_type'(i_ff - cnt_type'(1)),
                       lvl: lvl_ff + depth_type'(1), open: 1'b0};
            if ({1'b0, i_ff} >= {1'b0, lo_ff} + (CNT_W+1)'(2)) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + cnt_type'(1);
            end
            state_in = Q_POP;
         end

         M_INIT: begin
            stk_we   = 1'b1;
            stk_wa   = '0;
            stk_wd   = '{lo: '0, hi: addr_type'(n_ff - cnt_type'(1)),
                         lvl: depth_type'(1), open: 1'b0};
            sp_in    = cnt_type'(1);
            state_in = M_TOP;
         end
         M_TOP: begin
            state_in = (sp_ff == '0) ? E_DONE : M_FR;
         end
         M_FR: begin
            lo_in  = {1'b0, fr.lo};
            hi_in  = {1'b0, fr.hi};
            lvl_in = fr.lvl;
            mid_in = {1'b0, fr_mid};
            if (!fr.open) begin
               if (fr.lvl > dep_ff) begin
                  dep_in = fr.lvl;
               end
               if (fr.lo >= fr.hi) begin
                  sp_in    = sp_m1;
                  state_in = M_TOP;
               end else begin
                  stk_we   = 1'b1;
                  stk_wa   = sp_m1[IDX_W-1:0];
                  stk_wd   = '{lo: fr.lo, hi: fr.hi, lvl: fr.lvl, open: 1'b1};
                  state_in = M_P1;
               end
            end else begin
               i_in     = {1'b0, fr.lo};
               j_in     = {1'b0, fr_mid} + cnt_type'(1);
               k_in     = '0;
               state_in = R_L;
            end
         end
         M_P1: begin
            stk_we   = 1'b1;
            stk_wa   = sp_ff[IDX_W-1:0];
            stk_wd   = '{lo: addr_type'(mid_ff + cnt_type'(1)), hi: hi_ff[IDX_W-1:0],
                         lvl: lvl_ff + depth_type'(1), open: 1'b0};
            state_in = M_P2;
         end
         M_P2: begin
            stk_we   = 1'b1;
            stk_wa   = addr_type'(sp_ff + cnt_type'(1));
            stk_wd   = '{lo: lo_ff[IDX_W-1:0], hi: mid_ff[IDX_W-1:0],
                         lvl: lvl_ff + depth_type'(1), open: 1'b0};
            sp_in    = sp_ff + cnt_type'(2);
            state_in = M_TOP;
         end

         R_L: begin
            vs_req.rd_addr_a = i_ff[IDX_W-1:0];
            vs_req.rd_addr_b = j_ff[IDX_W-1:0];
            state_in = (i_ff <= mid_ff && j_ff <= hi_ff) ? R_C : R_T;
         end
         R_C: begin
            cmp_in = sat_inc(cmp_ff);
            scr_we = 1'b1;
            if (vs_rd_a <= vs_rd_b) begin
               scr_wd = vs_rd_a;
               i_in   = i_ff + cnt_type'(1);
            end else begin
               scr_wd = vs_rd_b;
               j_in   = j_ff + cnt_type'(1);
            end
            k_in     = k_ff + cnt_type'(1);
            state_in = R_L;
         end
         R_T: begin
            if (i_ff <= mid_ff) begin
               vs_req.rd_addr_a = i_ff[IDX_W-1:0];
               tail_a_in = 1'b1;
               state_in  = R_TW;
            end else if (j_ff <= hi_ff) begin
               vs_req.rd_addr_a = j_ff[IDX_W-1:0];
               tail_a_in = 1'b0;
               state_in  = R_TW;
            end else begin
               t_in     = '0;
               state_in = R_CP;
            end
         end
         R_TW: begin
            scr_we = 1'b1;
            scr_wd = vs_rd_a;
            k_in   = k_ff + cnt_type'(1);
            if (tail_a_ff) begin
               i_in = i_ff + cnt_type'(1);
            end else begin
               j_in = j_ff + cnt_type'(1);
            end
            state_in = R_T;
         end
         R_CP: begin
            if (t_ff < k_ff) begin
               state_in = R_CW;
            end else begin
               sp_in    = sp_m1;
               state_in = M_TOP;
            end
         end
         R_CW: begin
            vs_req.we      = 1'b1;
            vs_req.wr_addr = addr_type'(lo_ff + t_ff);
            vs_req.wr_data = scr_rd;
            t_in           = t_ff + cnt_type'(1);
            state_in       = R_CP;
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         cmp_ff   <= '0;
         swp_ff   <= '0;
         dep_ff   <= '0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cmp_ff   <= cmp_in;
         swp_ff   <= swp_in;
         dep_ff   <= dep_in;
         sp_ff    <= sp_in;
      end
      ret_ff <= ret_in;   n_ff <= n_in;
      i_ff <= i_in;       j_ff <= j_in;       k_ff <= k_in;       t_ff <= t_in;
      m_ff <= m_in;       root_ff <= root_in; big_ff <= big_in;   size_ff <= size_in;
      lo_ff <= lo_in;     hi_ff <= hi_in;     mid_ff <= mid_in;   lvl_ff <= lvl_in;
      vm_ff <= vm_in;     vi_ff <= vi_in;     va_ff <= va_in;     vb_ff <= vb_in;
      sa_ff <= sa_in;     sb_ff <= sb_in;
      tail_a_ff <= tail_a_in;
      hext_ff   <= hext_in;
   end

   mas_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ELEMENTS)) u_scratch (
      .clock (clock),
      .we    (scr_we),
      .wa    (scr_wa),
      .wd    (scr_wd),
      .ra_a  (scr_ra),
      .ra_b  (scr_ra),
      .rd_a  (scr_rd),
      .rd_b  ()
   );

   mas_ram #(.WIDTH($bits(frame_type)), .DEPTH(MAX_ELEMENTS)) u_stack (
      .clock (clock),
      .we    (stk_we),
      .wa    (stk_wa),
      .wd    (stk_wd),
      .ra_a  (stk_ra),
      .ra_b  (stk_ra),
      .rd_a  (stk_rd),
      .rd_b  ()
   );

endmodule

// ----- src/multi_algorithm_sorter.sv -----
// ----------------------------------------------------------------------------
// multi_algorithm_sorter
// loads a set of signed values, sorts it with the selected algorithm in the
// value store memory and streams the sorted set with run statistics
// ----------------------------------------------------------------------------
//  channel  | ports                        | beat moves
//  ---------+------------------------------+-------------------------------
//  request  | req_valid req_ready req_payload | one value, last flag
//  response | rsp_valid rsp_ready rsp_payload | one sorted value + totals
//  csr      | csr_write_enable csr_write_data | algorithm select
//
// loading takes one beat per cycle while req_ready is high; the last beat starts the sort
// the engine sequencer does the sort: compares read through the
// dual-read port, swaps write on the single write port, and merge copies
// each element back from scratch through that write port
// results are read one at a time from the value store read port
// reset clears control state only; stored values are not cleared
// a new set is taken while the final result still waits in the output register
module multi_algorithm_sorter import mas_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_payload_type  req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_payload_type  rsp_payload,
   input  logic             csr_write_enable,
   input  logic [ALG_W-1:0] csr_write_data
);

`include "multi_algorithm_sorter_assert.svh"

   typedef enum logic [1:0] {T_LOAD, T_SORT, T_RD, T_LD} state_type;

   state_type state_ff, state_in;
   cnt_type count_ff, count_in, n_ff, n_in, k_ff, k_in;
   logic ovf_ff, ovf_in, rsp_valid_ff, rsp_valid_in;
   logic [ALG_W-1:0] alg_ff, alg_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic req_beat, rsp_load, is_last;
   cnt_type n_next;
   eng_cmd_type eng_cmd;
   eng_res_type eng_res;
   vs_req_type eng_vs, top_vs, vs_port;
   value_type vs_rd_a, vs_rd_b;

   assign req_ready = (state_ff == T_LOAD);
   assign req_beat  = req_valid && req_ready;
   assign n_next    = (count_ff < cnt_type'(MAX_ELEMENTS)) ? count_ff + cnt_type'(1)
                                                          : count_ff;
   assign is_last   = (k_ff == n_ff - cnt_type'(1));
   assign rsp_load  = (state_ff == T_LD) && (!rsp_valid_ff || rsp_ready);

   assign eng_cmd.start = req_beat && req_payload.last_element;
   assign eng_cmd.n     = n_next;
   assign eng_cmd.alg   = alg_ff;

   always_comb begin
      top_vs.rd_addr_a = k_ff[IDX_W-1:0];
      top_vs.rd_addr_b = k_ff[IDX_W-1:0];
      top_vs.we        = req_beat && (count_ff < cnt_type'(MAX_ELEMENTS));
      top_vs.wr_addr   = count_ff[IDX_W-1:0];
      top_vs.wr_data   = req_payload.element_value;
      vs_port = (state_ff == T_SORT) ? eng_vs : top_vs;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      ovf_in       = ovf_ff;
      alg_in       = csr_write_enable ? csr_write_data : alg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         T_LOAD: begin
            if (req_beat) begin
               count_in = n_next;
               if (count_ff == cnt_type'(MAX_ELEMENTS)) begin
                  ovf_in = 1'b1;
               end
               if (req_payload.last_element) begin
                  n_in     = n_next;
                  state_in = T_SORT;
               end
            end
         end
         T_SORT: begin
            if (eng_res.done) begin
               k_in     = '0;
               state_in = T_RD;
            end
         end
         T_RD: state_in = T_LD;
         T_LD: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{sorted_value:     vs_rd_a,
                          position:         k_ff[IDX_W-1:0],
                          comparison_count: eng_res.cmp,
                          swap_count:       eng_res.swp,
                          max_depth:        eng_res.dep,
                          overflowed:       ovf_ff,
                          last_result:      is_last};
               if (is_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = T_LOAD;
               end else begin
                  k_in     = k_ff + cnt_type'(1);
                  state_in = T_RD;
               end
            end
         end
         default: state_in = T_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         alg_ff       <= ALG_BUBBLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         alg_ff       <= alg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff   <= n_in;
      k_ff   <= k_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   mas_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ELEMENTS)) u_value_store (
      .clock (clock),
      .we    (vs_port.we),
      .wa    (vs_port.wr_addr),
      .wd    (vs_port.wr_data),
      .ra_a  (vs_port.rd_addr_a),
      .ra_b  (vs_port.rd_addr_b),
      .rd_a  (vs_rd_a),
      .rd_b  (vs_rd_b)
   );

   mas_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cmd     (eng_cmd),
      .res     (eng_res),
      .vs_req  (eng_vs),
      .vs_rd_a (vs_rd_a),
      .vs_rd_b (vs_rd_b)
   );

   `MAS_ASSERT_IMPL(a_done_only_sorting, clock, reset, eng_res.done, state_ff == T_SORT)
   `MAS_ASSERT_IMPL(a_count_in_range, clock, reset, 1'b1,
                    count_ff <= cnt_type'(MAX_ELEMENTS))
   `MAS_ASSERT_NEXT(a_last_rearms_load, clock, reset, rsp_load && is_last,
                    state_ff == T_LOAD && count_ff == '0 && rsp_valid_ff)

endmodule

// ----- verif/multi_algorithm_sorter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_algorithm_sorter_checker
// watches the request, response and csr ports of the sorter, sorts every
// loaded set itself with the selected algorithm and compares each response
// beat field by field with the oldest expected sorted value
// ----------------------------------------------------------------------------
module multi_algorithm_sorter_checker import mas_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_payload_type  req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_payload_type  rsp_payload,
   input  logic             csr_write_enable,
   input  logic [ALG_W-1:0] csr_write_data,
   output int               error_count,
   output int               pending_results
);

   value_type       loaded_values [MAX_ELEMENTS];
   value_type       scratch_values [MAX_ELEMENTS];
   int              loaded_count;
   logic            dropped_any;
   logic [ALG_W-1:0] selected_alg;
   int              cmp_total;
   int              swp_total;
   int              depth_seen;
   rsp_payload_type sorted_results[$];

   assign pending_results = sorted_results.size();

   function automatic void bump_cmp();
      if (cmp_total < 4095) cmp_total++;
   endfunction

   function automatic void note_level(input int lvl);
      if (lvl > depth_seen) depth_seen = lvl;
   endfunction

   function automatic void exchange(input int a, input int b);
      value_type t;
      t = loaded_values[a];
      loaded_values[a] = loaded_values[b];
      loaded_values[b] = t;
      if (swp_total < 4095) swp_total++;
   endfunction

   function automatic void merge_range(input int lo, input int hi, input int lvl);
      int mid;
      int a;
      int b;
      int k;
      note_level(lvl);
      if (lo >= hi) return;
      mid = lo + (hi - lo) / 2;
      merge_range(lo, mid, lvl + 1);
      merge_range(mid + 1, hi, lvl + 1);
      a = lo;
      b = mid + 1;
      k = 0;
      while (a <= mid && b <= hi) begin
         bump_cmp();
         if (loaded_values[a] <= loaded_values[b]) scratch_values[k++] = loaded_values[a++];
         else scratch_values[k++] = loaded_values[b++];
      end
      while (a <= mid) scratch_values[k++] = loaded_values[a++];
      while (b <= hi) scratch_values[k++] = loaded_values[b++];
      for (int t = 0; t < k; t++) loaded_values[lo + t] = scratch_values[t];
   endfunction

   // lomuto partition, pivot is the last value of the range
   function automatic void quick_range(input int lo, input int hi, input int lvl);
      value_type pv;
      int i;
      pv = loaded_values[hi];
      i = lo;
      for (int j = lo; j < hi; j++) begin
         bump_cmp();
         if (loaded_values[j] < pv) exchange(i++, j);
      end
      exchange(i, hi);
      note_level(lvl + 1);
      if (hi - (i + 1) >= 1) quick_range(i + 1, hi, lvl + 1);
      if ((i - 1) - lo >= 1) quick_range(lo, i - 1, lvl + 1);
   endfunction

   function automatic void sift(input int size, input int root);
      int big;
      int l;
      int r;
      forever begin
         big = root;
         l = 2 * root + 1;
         r = 2 * root + 2;
         if (l < size) begin
            bump_cmp();
            if (loaded_values[l] > loaded_values[big]) big = l;
         end
         if (r < size) begin
            bump_cmp();
            if (loaded_values[r] > loaded_values[big]) big = r;
         end
         if (big == root) return;
         exchange(root, big);
         root = big;
      end
   endfunction

   function automatic void sort_loaded_set(input int n);
      int m;
      cmp_total = 0;
      swp_total = 0;
      depth_seen = 0;
      case (selected_alg)
         ALG_SELECTION: begin
            for (int i = 0; i < n; i++) begin
               m = i;
               for (int j = i + 1; j < n; j++) begin
                  bump_cmp();
                  if (loaded_values[j] < loaded_values[m]) m = j;
               end
               if (m != i) exchange(i, m);
            end
         end
         ALG_INSERTION: begin
            for (int i = 1; i < n; i++)
               for (int j = i; j > 0; j--) begin
                  bump_cmp();
                  if (loaded_values[j - 1] <= loaded_values[j]) break;
                  exchange(j - 1, j);
               end
         end
         ALG_MERGE: merge_range(0, n - 1, 1);
         ALG_QUICK: begin
            note_level(1);
            if (n >= 2) quick_range(0, n - 1, 1);
         end
         ALG_HEAP: begin
            for (int i = n / 2 - 1; i >= 0; i--) sift(n, i);
            for (int e = n - 1; e > 0; e--) begin
               exchange(0, e);
               sift(e, 0);
            end
         end
         // bubble, also for the unused selector codes
         default: begin
            for (int i = 0; i < n; i++)
               for (int j = 0; j + 1 < n - i; j++) begin
                  bump_cmp();
                  if (loaded_values[j] > loaded_values[j + 1]) exchange(j, j + 1);
               end
         end
      endcase
   endfunction

   function automatic void load_beat(input req_payload_type beat);
      rsp_payload_type r;
      if (loaded_count < MAX_ELEMENTS) loaded_values[loaded_count++] = beat.element_value;
      else dropped_any = 1'b1;
      if (!beat.last_element) return;
      sort_loaded_set(loaded_count);
      for (int k = 0; k < loaded_count; k++) begin
         r.sorted_value     = loaded_values[k];
         r.position         = addr_type'(k);
         r.comparison_count = total_type'(cmp_total);
         r.swap_count       = total_type'(swp_total);
         r.max_depth        = depth_type'(depth_seen);
         r.overflowed       = dropped_any;
         r.last_result      = (k == loaded_count - 1);
         sorted_results     = {sorted_results, r};
      end
      loaded_count = 0;
      dropped_any  = 1'b0;
   endfunction

   function automatic void check_beat(input rsp_payload_type got);
      rsp_payload_type want;
      logic bad;
      if (sorted_results.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("unexpected response beat: value %0d pos %0d",
                     got.sorted_value, got.position);
         return;
      end
      want = sorted_results.pop_front();
      bad = (got.sorted_value !== want.sorted_value) || (got.position !== want.position) ||
            (got.comparison_count !== want.comparison_count) ||
            (got.swap_count !== want.swap_count) || (got.max_depth !== want.max_depth) ||
            (got.overflowed !== want.overflowed) || (got.last_result !== want.last_result);
      if (bad) begin
         error_count++;
         if (error_count <= 10)
            $display("mismatch: exp val %0d pos %0d cmp %0d swp %0d dep %0d ovf %0b last %0b",
                     want.sorted_value, want.position, want.comparison_count,
                     want.swap_count, want.max_depth, want.overflowed, want.last_result,
                     "\n          got val %0d pos %0d cmp %0d swp %0d dep %0d ovf %0b last %0b",
                     got.sorted_value, got.position, got.comparison_count,
                     got.swap_count, got.max_depth, got.overflowed, got.last_result);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         loaded_count <= 0;
         dropped_any  <= 1'b0;
         selected_alg <= ALG_BUBBLE;
         error_count  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) check_beat(rsp_payload);
         if (req_valid && req_ready) load_beat(req_payload);
         if (csr_write_enable) selected_alg <= csr_write_data;
      end
   end

endmodule

// ----- verif/tb_multi_algorithm_sorter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_algorithm_sorter
// drives value sets through the sorter under every algorithm selector and
// several idle and stall mixes; the checker predicts and compares each beat
// ----------------------------------------------------------------------------
module tb_multi_algorithm_sorter;
   import mas_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_payload_type  req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_payload_type  rsp_payload;
   logic             csr_write_enable = 1'b0;
   logic [ALG_W-1:0] csr_write_data = '0;
   int               error_count;
   int               pending_results;
   int               idle_pct = 0;
   int               stall_pct = 0;
   int               cycle_count = 0;

   always #10 clock = ~clock;

   multi_algorithm_sorter i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   multi_algorithm_sorter_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_results  (pending_results)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_beat(input value_type v, input logic lst);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{element_value: v, last_element: lst};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_set(input value_type vals[$]);
      foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
      req_valid <= 1'b0;
   endtask

   // csr writes only with the sorter drained and idle
   task automatic select_alg(input logic [ALG_W-1:0] alg);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_results == 0);
      repeat (20) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= alg;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic value_type pick_value(input int mode);
      case (mode)
         0: return value_type'($urandom);
         1: return value_type'($signed($urandom_range(8)) - 4);
         default: begin
            case ($urandom_range(3))
               0: return 32'sh7fff_ffff;
               1: return 32'sh8000_0000;
               2: return 32'sh0;
               default: return -32'sd1;
            endcase
         end
      endcase
   endfunction

   task automatic random_set(input int size);
      value_type vals[$];
      int mode;
      int order;
      mode  = $urandom_range(2);
      order = $urandom_range(5);
      repeat (size) vals = {vals, pick_value(mode)};
      if (order == 0) vals.sort();
      else if (order == 1) vals.rsort();
      send_set(vals);
   endtask

   initial begin
      value_type vals[$];
      int sz;
      logic [ALG_W-1:0] alg_plan[12] = '{ALG_BUBBLE, ALG_SELECTION, ALG_INSERTION,
         ALG_MERGE, ALG_QUICK, ALG_HEAP, 3'd6, 3'd7, ALG_HEAP, ALG_QUICK, ALG_MERGE,
         ALG_BUBBLE};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed sets: extremes, duplicates, single value, reversed run
      send_set('{32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 1, 32'sh8000_0000, 32'sh7fff_ffff});
      send_set('{32'sh5a5a_a5a5});
      send_set('{3, 3, 3});
      send_set('{4, 3, 2, 1, 0, -1, -2});
      send_set('{32'sh8000_0000, 32'sh7fff_ffff});
      select_alg(ALG_QUICK);
      send_set('{1, 2, 3, 4, 5});

      for (int ph = 0; ph < 12; ph++) begin
         select_alg(alg_plan[ph]);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 61; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 61; end
            default: begin idle_pct = 9; stall_pct = 9; end
         endcase
         // full capacity sorted set drives quick sort to its deepest level
         if (ph == 4) begin
            vals.delete();
            for (int i = 0; i < MAX_ELEMENTS; i++) vals = {vals, value_type'(i * 3 - 90)};
            send_set(vals);
         end
         // more values than capacity, the tail is dropped
         if (ph == 8) random_set(MAX_ELEMENTS + 3);
         sz = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         random_set(sz);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_results == 0);
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_results == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
